/* design/tdp_pkg.sv */
// shared types and constants for the trial division prime test unit
package tdp_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int CAND_WIDTH  = 32;
    localparam int CNT_WIDTH   = $clog2(VALUE_WIDTH + 1);

    typedef logic [VALUE_WIDTH-1:0] t_value;
    typedef logic [CNT_WIDTH-1:0]   t_count;

    localparam t_value FIRST_DIVISOR = t_value'(2);
    localparam t_value FIRST_ODD     = t_value'(3);
    localparam t_value ODD_STEP      = t_value'(2);

    typedef struct packed {
        logic   start;
        t_value dividend;
        t_value divisor;
    } t_div_req;

    typedef struct packed {
        logic   done;
        t_value quotient;
        logic   rem_zero;
    } t_div_rsp;

endpackage

/* design/tdp_cand_if.sv */
// candidate channel carrying one number to test per beat
interface tdp_cand_if;
    logic                           valid;
    logic                           ready;
    logic [tdp_pkg::CAND_WIDTH-1:0] candidate;

    modport source (output valid, output candidate, input ready);
    modport sink (input valid, input candidate, output ready);
endinterface

/* design/tdp_result_if.sv */
// result channel carrying one primality verdict per beat
interface tdp_result_if;
    logic valid;
    logic ready;
    logic is_prime;

    modport source (output valid, output is_prime, input ready);
    modport sink (input valid, input is_prime, output ready);
endinterface

/* design/trial_division_prime_test_unit.sv */
// top level: trial division sequencer around the bit-serial divider
// usage:
//   i_cand is a valid/ready sink carrying one 32-bit unsigned candidate per beat;
//   the low VALUE_WIDTH bits are tested. o_result is a valid/ready source that
//   carries one is_prime bit per candidate, in order.
//   one candidate is worked on at a time; i_cand.ready is high only while the
//   sequencer is idle. candidates below two go straight to the hold state with
//   a false verdict. otherwise divisors 2, 3, 5, 7, ... are tried while the
//   divisor does not exceed candidate / divisor; each trial is one pass of the
//   serial divider, which handles one dividend bit per cycle. the number of odd
//   divisors tried is at most about 2^(VALUE_WIDTH/2 - 1).
//   the verdict goes to an output register, so a new candidate is accepted
//   while the previous verdict still waits for o_result.ready; a finished
//   verdict waits in the sequencer only if that register is still full.
//   synchronous active-low reset empties the output register and returns the
//   sequencer to idle; no stored state survives between candidates.
module trial_division_prime_test_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    tdp_cand_if.sink     i_cand,
    tdp_result_if.source o_result
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_START,
        S_WAIT,
        S_HOLD
    } t_state;

    t_state            r_state;
    tdp_pkg::t_value   r_n;
    tdp_pkg::t_value   r_d;
    logic              r_res;
    logic              r_out_valid;
    logic              r_out_prime;
    tdp_pkg::t_value   n_n;
    tdp_pkg::t_div_req div_req;
    tdp_pkg::t_div_rsp div_rsp;
    logic              cand_beat;
    logic              out_free;

    assign n_n       = tdp_pkg::t_value'(i_cand.candidate);
    assign cand_beat = i_cand.valid && i_cand.ready;
    assign out_free  = !r_out_valid || o_result.ready;

    always_comb begin
        i_cand.ready     = (r_state == S_IDLE);
        div_req.start    = (r_state == S_START);
        div_req.dividend = r_n;
        div_req.divisor  = r_d;
    end

    tdp_serial_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (div_req),
        .o_rsp  (div_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            // the hold state reloads the output register itself
            if (r_out_valid && o_result.ready && (r_state != S_HOLD)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (cand_beat) begin
                        r_n <= n_n;
                        r_d <= tdp_pkg::FIRST_DIVISOR;
                        if (n_n[tdp_pkg::VALUE_WIDTH-1:1] == '0) begin
                            r_res   <= 1'b0;
                            r_state <= S_HOLD;
                        end else begin
                            r_state <= S_START;
                        end
                    end
                end
                S_START: begin
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    if (div_rsp.done) begin
                        // divisor above the quotient means it passed the square root
                        if (r_d > div_rsp.quotient) begin
                            r_res   <= 1'b1;
                            r_state <= S_HOLD;
                        end else if (div_rsp.rem_zero) begin
                            r_res   <= 1'b0;
                            r_state <= S_HOLD;
                        end else begin
                            // even divisors past two cannot divide an odd candidate
                            r_d     <= (r_d == tdp_pkg::FIRST_DIVISOR) ?
                                       tdp_pkg::FIRST_ODD : r_d + tdp_pkg::ODD_STEP;
                            r_state <= S_START;
                        end
                    end
                end
                S_HOLD: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_prime <= r_res;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_result.valid    = r_out_valid;
    assign o_result.is_prime = r_out_prime;

    // a candidate beat always leaves the sequencer busy on the next cycle
    a_busy_after_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cand_beat |=> !i_cand.ready)
        else $error("candidate beat did not start work");

    // divisor answers arrive only while the sequencer waits for them
    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == S_WAIT))
        else $error("divider finished outside the wait state");

    // a new verdict appears only when the sequencer hands one over
    a_verdict_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_result.valid) |-> $past(r_state == S_HOLD))
        else $error("result beat raised without a finished candidate");

    // after the first trial only odd divisors are used
    a_odd_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_START) && (r_d != tdp_pkg::FIRST_DIVISOR)) |-> r_d[0])
        else $error("even divisor beyond two");

endmodule

/* design/tdp_serial_div.sv */
// restoring divider that shifts in one dividend bit per cycle
module tdp_serial_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tdp_pkg::t_div_req i_req,
    output tdp_pkg::t_div_rsp o_rsp
);

    logic                              r_busy, n_busy;
    logic                              r_done, n_done;
    tdp_pkg::t_count                   r_cnt, n_cnt;
    tdp_pkg::t_value                   r_rem, n_rem;
    tdp_pkg::t_value                   r_quo, n_quo;
    tdp_pkg::t_value                   r_dsr, n_dsr;
    logic [tdp_pkg::VALUE_WIDTH:0]     trial;
    logic [tdp_pkg::VALUE_WIDTH:0]     diff;
    logic                              ge;

    // bring down the next dividend bit and try the subtraction
    assign trial = {r_rem, r_quo[tdp_pkg::VALUE_WIDTH-1]};
    assign diff  = trial - {1'b0, r_dsr};
    assign ge    = (trial >= {1'b0, r_dsr});

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_dsr  = r_dsr;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = tdp_pkg::t_count'(tdp_pkg::VALUE_WIDTH);
            n_rem  = '0;
            n_quo  = i_req.dividend;
            n_dsr  = i_req.divisor;
        end else if (r_busy) begin
            // dividend bits leave at the top while quotient bits enter at the bottom
            n_rem = ge ? diff[tdp_pkg::VALUE_WIDTH-1:0] : trial[tdp_pkg::VALUE_WIDTH-1:0];
            n_quo = {r_quo[tdp_pkg::VALUE_WIDTH-2:0], ge};
            n_cnt = r_cnt - tdp_pkg::t_count'(1);
            if (r_cnt == tdp_pkg::t_count'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_dsr <= n_dsr;
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;
    assign o_rsp.rem_zero = (r_rem == '0);

endmodule

/* sim/trial_division_prime_test_unit_tb.sv */
// testbench for the trial division prime test unit: directed and random candidates, checked verdicts
`timescale 1ns / 100ps

module trial_division_prime_test_unit_tb;

    localparam int          CYCLE_LIMIT = 4_000_000;
    localparam int          TAIL_CYCLES = 20;
    localparam int          RANDOM_ITEMS = 80;
    localparam logic [31:0] SMALL_FACTORS [6] = '{2, 3, 5, 7, 11, 13};

    typedef struct {
        logic [tdp_pkg::CAND_WIDTH-1:0] value;
        logic                           after_drain;
    } t_cand_item;

    logic i_clk;
    logic i_rst_n;

    tdp_cand_if   cand_bus ();
    tdp_result_if verdict_bus ();

    trial_division_prime_test_unit dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cand   (cand_bus.sink),
        .o_result (verdict_bus.source)
    );

    t_cand_item  cand_pending [$];
    logic        verdict_q [$];
    logic [31:0] verdict_cand_q [$];
    int unsigned accepted_cnt;
    int unsigned checked_cnt;
    int unsigned send_hold;
    int unsigned ready_stall;
    int unsigned error_cnt = 0;
    int unsigned cycle_cnt = 0;

    // exact trial division at the block's value width
    function automatic logic primality_of(input logic [tdp_pkg::CAND_WIDTH-1:0] cand);
        logic [63:0] n;
        logic [63:0] d;
        n = 64'(tdp_pkg::t_value'(cand));
        if (n < 64'd2) return 1'b0;
        for (d = 64'd2; d <= n / d; d++) begin
            if (n % d == 64'd0) return 1'b0;
        end
        return 1'b1;
    endfunction

    // mostly no gap, some short, a few long
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 4);
        return $urandom_range(12, 70);
    endfunction

    // small numbers keep primes cheap; wide ones get a small factor so they finish fast
    function automatic logic [31:0] random_candidate();
        int unsigned r;
        logic [31:0] v;
        logic [31:0] p;
        r = $urandom_range(0, 99);
        if (r < 10) return $urandom_range(0, 3);
        if (r < 65) return $urandom_range(4, 4095);
        if (r < 80) return $urandom_range(4096, 32'h000F_FFFF);
        p = SMALL_FACTORS[$urandom_range(0, 5)];
        v = $urandom;
        v = v - (v % p);
        if (v < 2 * p) v = p * p;
        return v;
    endfunction

    function automatic void add_item(input logic [31:0] value, input logic after_drain);
        t_cand_item it;
        it.value       = value;
        it.after_drain = after_drain;
        cand_pending   = {cand_pending, it};
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // sender
    always @(posedge i_clk) begin
        logic        fire;
        logic        can_send;
        int unsigned g;
        fire = cand_bus.valid && cand_bus.ready;
        if (!i_rst_n) begin
            cand_bus.valid     <= 1'b0;
            cand_bus.candidate <= '0;
            send_hold          <= 0;
        end else if (fire || !cand_bus.valid) begin
            g = fire ? pick_gap() : send_hold;
            can_send = cand_pending.size() > 0;
            if (can_send && cand_pending[0].after_drain)
                can_send = !fire && accepted_cnt == checked_cnt;
            if (g > 0) begin
                send_hold      <= g - 1;
                cand_bus.valid <= 1'b0;
            end else if (can_send) begin
                cand_bus.valid     <= 1'b1;
                cand_bus.candidate <= cand_pending[0].value;
                cand_pending.pop_front();
            end else begin
                cand_bus.valid <= 1'b0;
            end
        end
    end

    // receiver: check each verdict beat, record newly accepted candidates, then stall
    always @(posedge i_clk) begin
        logic        want;
        logic [31:0] cand;
        int unsigned s;
        if (!i_rst_n) begin
            verdict_bus.ready <= 1'b0;
            ready_stall       <= 0;
            accepted_cnt      <= 0;
            checked_cnt       <= 0;
        end else begin
            if (verdict_bus.valid && verdict_bus.ready) begin
                checked_cnt <= checked_cnt + 1;
                if (verdict_q.size() == 0) begin
                    $display("%0t: unexpected verdict beat is_prime=%0b", $time,
                             verdict_bus.is_prime);
                    error_cnt++;
                end else begin
                    want = verdict_q.pop_front();
                    cand = verdict_cand_q.pop_front();
                    if (verdict_bus.is_prime !== want) begin
                        $display("%0t: candidate %0d is_prime expected %0b actual %0b",
                                 $time, cand, want, verdict_bus.is_prime);
                        error_cnt++;
                    end
                end
            end
            if (cand_bus.valid && cand_bus.ready) begin
                accepted_cnt   <= accepted_cnt + 1;
                verdict_q      = {verdict_q, primality_of(cand_bus.candidate)};
                verdict_cand_q = {verdict_cand_q, cand_bus.candidate};
            end
            if (ready_stall > 0) begin
                ready_stall       <= ready_stall - 1;
                verdict_bus.ready <= 1'b0;
            end else begin
                s = pick_gap();
                if (s > 0) begin
                    ready_stall       <= s - 1;
                    verdict_bus.ready <= 1'b0;
                end else begin
                    verdict_bus.ready <= 1'b1;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d verdicts outstanding", $time, verdict_q.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        i_rst_n <= 1'b0;

        // edge values, smallest primes, prime squares, wide patterns
        add_item(32'd0, 1'b0);
        add_item(32'd1, 1'b0);
        add_item(32'd2, 1'b0);
        add_item(32'd3, 1'b0);
        add_item(32'd4, 1'b0);
        add_item(32'd5, 1'b0);
        add_item(32'd9, 1'b0);
        add_item(32'd25, 1'b0);
        add_item(32'd49, 1'b0);
        add_item(32'd63001, 1'b0);
        add_item(32'd65535, 1'b0);
        add_item(32'd65537, 1'b0);
        add_item(32'd16752649, 1'b0);
        add_item(32'd16777213, 1'b0);
        add_item(32'hFFFF_FFFF, 1'b0);
        add_item(32'hFFFF_FFFE, 1'b0);
        add_item(32'h8000_0000, 1'b0);
        add_item(32'hAAAA_AAAA, 1'b0);
        add_item(32'h5555_5555, 1'b0);
        add_item(32'd4294836225, 1'b0);
        // this beat is sent only after every earlier verdict has been checked
        add_item(32'd7, 1'b1);
        for (int i = 0; i < RANDOM_ITEMS; i++)
            add_item(random_candidate(), i == RANDOM_ITEMS / 2);

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (cand_pending.size() > 0 || cand_bus.valid || accepted_cnt != checked_cnt)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        #1;
        if (verdict_q.size() > 0) begin
            $display("%0t: %0d verdicts never arrived", $time, verdict_q.size());
        end
        if (error_cnt == 0 && verdict_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
